// ----- hdl/mbc1_pkg.sv -----
// ----------------------------------------------------------------------------
// mbc1_pkg
// Shared types, codes and widths for the MBC1-style bank mapper.
// ----------------------------------------------------------------------------
package mbc1_pkg;

  localparam int ROM_BANK_BITS  = 5;
  localparam int ROM_PAGE_BITS  = 14;
  localparam int ROM_ADDR_W     = ROM_BANK_BITS + ROM_PAGE_BITS;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int RAM_OFF_W      = $clog2(RAM_BANK_BYTES);
  localparam int RAM_SEL_W      = 2;
  localparam int RAM_BANKS_DEF  = 4;
  localparam int ADDR_W         = 16;
  localparam int DATA_W         = 8;
  localparam int SIZE_W         = 3;

  // bus_addr[15:13] regions
  localparam logic [2:0] REGION_RAM_EN   = 3'd0;
  localparam logic [2:0] REGION_ROM_BANK = 3'd1;
  localparam logic [2:0] REGION_RAM_BANK = 3'd2;
  localparam logic [2:0] REGION_MODE     = 3'd3;
  localparam logic [2:0] REGION_RAM      = 3'd5;

  localparam logic [1:0] PAGE_ROM_FIXED  = 2'd0;
  localparam logic [1:0] PAGE_ROM_BANKED = 2'd1;

  localparam logic [3:0] RAM_EN_KEY   = 4'hA;
  localparam logic [7:0] OPEN_BUS     = 8'hFF;

  // ram_size_code values
  localparam logic [SIZE_W-1:0] SIZE_ONE     = 3'd2;
  localparam logic [SIZE_W-1:0] SIZE_FOUR    = 3'd3;
  localparam logic [SIZE_W-1:0] SIZE_SIXTEEN = 3'd4;
  localparam logic [SIZE_W-1:0] SIZE_EIGHT   = 3'd5;

  // configuration register indexes (paddr[2])
  localparam logic CFG_MAPPER_MODE = 1'b0;
  localparam logic CFG_RAM_SIZE    = 1'b1;

  typedef enum logic [1:0] {
    KIND_ROM   = 2'd0,
    KIND_RAM   = 2'd1,
    KIND_OPEN  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [ROM_ADDR_W-1:0] rom_addr;
    logic                  ram_rd;
    logic                  ram_wr;
    logic [RAM_SEL_W-1:0]  eff_bank;
  } dec_t;

endpackage

// ----- hdl/mbc1_ram.sv -----
// ----------------------------------------------------------------------------
// mbc1_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbc1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/mbc1_decode.sv -----
// ----------------------------------------------------------------------------
// mbc1_decode
// Bank registers and per-transfer address decode of the mapper.
// ----------------------------------------------------------------------------
module mbc1_decode #(
  parameter int RAM_BANKS = mbc1_pkg::RAM_BANKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               mapper_mode,
  input  logic [mbc1_pkg::SIZE_W-1:0]        ram_size_code,
  input  logic                               take,
  input  logic                               opcode,
  input  logic [mbc1_pkg::ADDR_W-1:0]        bus_addr,
  input  logic [mbc1_pkg::DATA_W-1:0]        write_data,
  output mbc1_pkg::dec_t                     dec
);
  import mbc1_pkg::*;

  localparam int LIM_W = RAM_SEL_W + 1;
  localparam logic [LIM_W-1:0] BANK_LIM = LIM_W'(RAM_BANKS);

  logic                     ram_enabled, ram_enabled_next;
  logic [ROM_BANK_BITS-1:0] rom_bank, rom_bank_next;
  logic [RAM_SEL_W-1:0]     ram_bank_select, ram_bank_select_next;
  logic                     bank_mode, bank_mode_next;

  logic [2:0]           region;
  logic [RAM_SEL_W-1:0] bank;
  logic                 code_ok;
  logic                 usable;

  assign region = bus_addr[ADDR_W-1 -: 3];
  assign bank   = bank_mode ? ram_bank_select : '0;

  always_comb begin
    unique case (ram_size_code)
      SIZE_ONE:     code_ok = (bank == '0);
      SIZE_FOUR:    code_ok = 1'b1;
      SIZE_SIXTEEN: code_ok = 1'b1;
      SIZE_EIGHT:   code_ok = 1'b1;
      default:      code_ok = 1'b0;
    endcase
  end

  assign usable = ram_enabled && code_ok && ({1'b0, bank} < BANK_LIM);

  always_comb begin
    ram_enabled_next     = ram_enabled;
    rom_bank_next        = rom_bank;
    ram_bank_select_next = ram_bank_select;
    bank_mode_next       = bank_mode;
    dec.kind     = KIND_OPEN;
    dec.rom_addr = '0;
    dec.ram_rd   = 1'b0;
    dec.ram_wr   = 1'b0;
    dec.eff_bank = bank;
    if (opcode) begin
      dec.kind = KIND_WRITE;
      if (mapper_mode) begin
        unique case (region)
          REGION_RAM_EN:   ram_enabled_next = (write_data[3:0] == RAM_EN_KEY);
          REGION_ROM_BANK: begin
            rom_bank_next = write_data[ROM_BANK_BITS-1:0];
            if (rom_bank_next == '0) begin
              rom_bank_next = ROM_BANK_BITS'(1);
            end
          end
          REGION_RAM_BANK: ram_bank_select_next = write_data[RAM_SEL_W-1:0];
          REGION_MODE:     bank_mode_next = write_data[0];
          REGION_RAM:      dec.ram_wr = usable;
          default: ;
        endcase
      end
    end else if (!mapper_mode || bus_addr[ADDR_W-1 -: 2] == PAGE_ROM_FIXED) begin
      dec.kind     = KIND_ROM;
      dec.rom_addr = ROM_ADDR_W'(bus_addr);
    end else if (bus_addr[ADDR_W-1 -: 2] == PAGE_ROM_BANKED) begin
      dec.kind     = KIND_ROM;
      dec.rom_addr = {rom_bank, bus_addr[ROM_PAGE_BITS-1:0]};
    end else if (region == REGION_RAM && usable) begin
      dec.kind   = KIND_RAM;
      dec.ram_rd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enabled     <= 1'b1;
      rom_bank        <= ROM_BANK_BITS'(1);
      ram_bank_select <= '0;
      bank_mode       <= 1'b0;
    end else if (take) begin
      ram_enabled     <= ram_enabled_next;
      rom_bank        <= rom_bank_next;
      ram_bank_select <= ram_bank_select_next;
      bank_mode       <= bank_mode_next;
    end
  end

endmodule

// ----- hdl/mbc1_bank_mapper.sv -----
// ----------------------------------------------------------------------------
// mbc1_bank_mapper
// MBC1-style cartridge bank mapper: bank registers, ROM address translation
// and banked external RAM.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_stall     opcode, bus_addr, write_data
//   out      source     out_valid / out_stall   result_kind, rom_addr, read_data
//   config   APB        psel/penable/pready     paddr, pwdata, prdata
//
// One transfer per cycle while in_stall is low; a result is registered in the
// decode stage, then the output register. Synchronous reset, then a clearing
// pass zeroes all RAM_BANKS * 8192 bytes via the RAM write port, in_stall high.
// A stalled output holds its result and one more transfer is taken behind it.
// ----------------------------------------------------------------------------
module mbc1_bank_mapper #(
  parameter int RAM_BANKS = mbc1_pkg::RAM_BANKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [mbc1_pkg::ADDR_W-1:0]         bus_addr,
  input  logic [mbc1_pkg::DATA_W-1:0]         write_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          result_kind,
  output logic [mbc1_pkg::ROM_ADDR_W-1:0]     rom_addr,
  output logic [mbc1_pkg::DATA_W-1:0]         read_data
);
  import mbc1_pkg::*;

  localparam int DEPTH = RAM_BANKS * RAM_BANK_BYTES;
  localparam int AW    = $clog2(DEPTH);

  logic              mapper_mode;
  logic [SIZE_W-1:0] ram_size_code;
  logic              cfg_wr;

  logic take;
  dec_t dec;

  logic          clr_active;
  logic [AW-1:0] clr_addr;

  logic [RAM_SEL_W+RAM_OFF_W-1:0] ram_full;
  logic [AW-1:0]                  ram_a;
  logic                           ram_we;
  logic [AW-1:0]                  ram_wa;
  logic [DATA_W-1:0]              ram_wd;
  logic [DATA_W-1:0]              ram_q;

  logic                  s1_valid;
  kind_t                 s1_kind;
  logic [ROM_ADDR_W-1:0] s1_rom_addr;
  logic                  s1_move;

  kind_t out_kind;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_mode   <= 1'b1;
      ram_size_code <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        CFG_MAPPER_MODE: mapper_mode   <= pwdata[0];
        CFG_RAM_SIZE:    ram_size_code <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_MAPPER_MODE: prdata = 32'(mapper_mode);
      CFG_RAM_SIZE:    prdata = 32'(ram_size_code);
      default:         prdata = '0;
    endcase
  end

  // handshake
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = clr_active || (s1_valid && !s1_move);
  assign take     = in_valid && !in_stall;

  mbc1_decode #(
    .RAM_BANKS (RAM_BANKS)
  ) u_decode (
    .clk           (clk),
    .rst           (rst),
    .mapper_mode   (mapper_mode),
    .ram_size_code (ram_size_code),
    .take          (take),
    .opcode        (opcode),
    .bus_addr      (bus_addr),
    .write_data    (write_data),
    .dec           (dec)
  );

  // clear the RAM after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  assign ram_full = {dec.eff_bank, bus_addr[RAM_OFF_W-1:0]};
  assign ram_a    = ram_full[AW-1:0];
  assign ram_we   = clr_active || (take && dec.ram_wr);
  assign ram_wa   = clr_active ? clr_addr : ram_a;
  assign ram_wd   = clr_active ? '0 : write_data;

  mbc1_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .re    (take && dec.ram_rd),
    .raddr (ram_a),
    .rdata (ram_q)
  );

  // decode stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_kind     <= dec.kind;
      s1_rom_addr <= dec.rom_addr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_kind <= s1_kind;
      rom_addr <= s1_rom_addr;
      unique case (s1_kind)
        KIND_RAM:  read_data <= ram_q;
        KIND_OPEN: read_data <= OPEN_BUS;
        default:   read_data <= '0;
      endcase
    end
  end

  assign result_kind = out_kind;

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !take)
    else $error("transfer taken during RAM clear");

  a_take_fills_stage: assert property (@(posedge clk) disable iff (rst)
    take |=> s1_valid)
    else $error("decode stage empty after transfer");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |=> (s1_valid && $stable(s1_kind)))
    else $error("decode stage lost under output stall");

  a_ram_write_is_write: assert property (@(posedge clk) disable iff (rst)
    (take && dec.ram_wr) |-> (dec.kind == KIND_WRITE && !dec.ram_rd))
    else $error("RAM write without write transfer");

  a_out_after_move: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("result dropped between stages");

endmodule
